@@ hw/rtl/ura_pkg.sv @@
// Shared constants, types and helper functions for the radix ASCII converter.
package ura_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 64;

   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_LO = 7'd87;  // 'a' less ten
   localparam logic [DIGIT_W-1:0] DEC_LIMIT    = 4'd10;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // out-of-range bases fold to the nearest legal one
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DEC_LIMIT) begin
         res = CHAR_ZERO + {3'b000, d};
      end else begin
         res = CHAR_ALPHA_LO + {3'b000, d};
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/ura_div.sv @@
// Bit-serial restoring divider: value by a small radix, one quotient bit per cycle.
module ura_div #(
   parameter int VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_WIDTH-1:0]         dividend,
   input  logic [ura_pkg::RADIX_W-1:0]    divisor,
   output logic [VALUE_WIDTH-1:0]         quotient,
   output logic [ura_pkg::DIGIT_W-1:0]    remainder,
   output ura_pkg::div_stat_type          stat
);

   localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0]          q_ff, q_in;
   logic [ura_pkg::DIGIT_W-1:0]     r_ff, r_in;
   logic [ura_pkg::RADIX_W-1:0]     d_ff, d_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ura_pkg::RADIX_W-1:0]     trial;
   logic [ura_pkg::RADIX_W-1:0]     diff;
   logic                            fits;

   // partial remainder stays below the divisor, so four bits hold it
   assign trial = {r_ff, q_ff[VALUE_WIDTH-1]};
   assign diff  = trial - d_ff;
   assign fits  = (trial >= d_ff);

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == '0);
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CNT_TOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_WIDTH-2:0], fits};
         r_in   = fits ? diff[ura_pkg::DIGIT_W-1:0] : trial[ura_pkg::DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hw/rtl/ura_digit_mem.sv @@
// Digit store: one write port, one registered read port.
module ura_digit_mem #(
   parameter int DEPTH = ura_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [ura_pkg::DIGIT_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [ura_pkg::DIGIT_W-1:0]   rd_data
);

   logic [ura_pkg::DIGIT_W-1:0] mem [DEPTH];
   logic [ura_pkg::DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/unsigned_to_radix_ascii_core.sv @@
// Top level: unsigned value to ASCII digits in radix 2..16, most significant first.
//
//   channel | dir | ports                                 | transfer when
//   --------+-----+---------------------------------------+----------------------------
//   req     | in  | req_value[63:0], req_radix[4:0]       | req_valid && !req_stall
//   rsp     | out | rsp_digit_char[6:0], rsp_last_digit   | rsp_valid && !rsp_stall
//
// Each digit comes from the bit-serial divider, the single shared unit;
//   emission then reads each digit from the store, then presents it.
// One item at a time: req_stall is high from the accepting edge until the
//   last digit has been transferred.
// Reset is synchronous and clears the sequencer and divider control only.
// A stalled result holds: the store read register is not reloaded meanwhile.
// Conversions needing more than MAX_DIGITS digits keep the low MAX_DIGITS.
module unsigned_to_radix_ascii_core #(
   parameter int VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = ura_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [63:0]                   req_value,
   input  logic [ura_pkg::RADIX_W-1:0]   req_radix,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ura_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_digit
);

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_SHOW   = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;      // digits stored so far
   logic [ADDR_W-1:0]            emit_idx_ff, emit_idx_in; // next digit to send
   logic [ura_pkg::RADIX_W-1:0]  radix_ff, radix_in;

   logic                         req_xfer;
   logic                         rsp_xfer;
   logic                         div_start;
   logic [VALUE_WIDTH-1:0]       div_dividend;
   logic [VALUE_WIDTH-1:0]       div_quot;
   logic [ura_pkg::DIGIT_W-1:0]  div_rem;
   ura_pkg::div_stat_type        div_stat;
   logic                         more_digits;
   logic                         mem_wr_en;
   logic                         mem_rd_en;
   logic [ura_pkg::DIGIT_W-1:0]  mem_rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_SHOW);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // keep dividing while quotient is non-zero and the store has room
   assign more_digits = (div_quot != '0) && (count_ff != CNT_LAST);
   assign mem_wr_en   = (state_ff == ST_DIVIDE) && div_stat.done;
   assign mem_rd_en   = (state_ff == ST_FETCH);

   // the first division takes the masked input, later ones the last quotient
   assign div_dividend = req_xfer ? req_value[VALUE_WIDTH-1:0] : div_quot;
   assign div_start    = req_xfer || (mem_wr_en && more_digits);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      emit_idx_in = emit_idx_ff;
      radix_in    = radix_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               radix_in = ura_pkg::clamp_radix(req_radix);
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               count_in = count_ff + 1'b1;
               if (!more_digits) begin
                  // most significant digit sits at the highest stored index
                  emit_idx_in = count_ff[ADDR_W-1:0];
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_xfer) begin
               if (emit_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff - 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      emit_idx_ff <= emit_idx_in;
      radix_ff    <= radix_in;
   end

   ura_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (req_xfer ? ura_pkg::clamp_radix(req_radix) : radix_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   ura_digit_mem #(
      .DEPTH (MAX_DIGITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_rem),
      .rd_en   (mem_rd_en),
      .rd_addr (emit_idx_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_digit_char = ura_pkg::ascii_of(mem_rd_data);
   assign rsp_last_digit = (emit_idx_ff == '0);

   // ---- checks ----

   // an accepted request always launches the divider
   a_start_on_req : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> div_stat.busy)
      else $error("divider not started after request transfer");

   // divider only finishes while the sequencer waits for it
   a_done_in_divide : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide phase");

   // after a non-final digit rsp_valid drops while the store is read, then returns
   a_gap_after_digit : assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_last_digit) |=> !rsp_valid ##1 rsp_valid)
      else $error("digit emission sequence broken");

   // no new request while results are still outstanding
   a_busy_while_emitting : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid || div_stat.busy) |-> req_stall)
      else $error("request taken while conversion in progress");

endmodule

@@ tb/sv/unsigned_to_radix_ascii_core_tb.sv @@
// Self-checking testbench for the radix ASCII converter: directed table, then random items.
module unsigned_to_radix_ascii_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Block configuration under test; the predictor follows the same sizes.
   localparam int VALUE_W   = ura_pkg::VALUE_WIDTH_DEF;
   localparam int DIGIT_CAP = (ura_pkg::MAX_DIGITS_DEF > 64) ? 64 : ura_pkg::MAX_DIGITS_DEF;
   localparam logic [63:0] VALUE_MASK = (VALUE_W >= 64) ? {64{1'b1}}
                                                        : ((64'd1 << VALUE_W) - 64'd1);

   // Slowest silent stretch: a 64-digit conversion, plus the long receiver hold
   // and a long stall on top. Taken several times.
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int LONG_HOLD      = 500;   // receiver hold-off while the sender keeps offering
   localparam int DRAIN_CYCLES   = 500;   // quiet spell at the end to catch stray digits
   localparam int RANDOM_ITEMS   = 95;
   localparam int MAX_PRINTS     = 50;

   localparam int DIRECTED_ROWS  = 25;

   typedef struct packed {
      logic [63:0]                 value;
      logic [ura_pkg::RADIX_W-1:0] radix;
   } conv_req_type;

   typedef struct packed {
      logic [ura_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } digit_exp_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [63:0]                  req_value;
   logic [ura_pkg::RADIX_W-1:0]  req_radix;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [ura_pkg::CHAR_W-1:0]   rsp_digit_char;
   logic                         rsp_last_digit;

   digit_exp_type expected_digits [$];
   string      pending_text;        // typed-in answer for the item on offer, empty = predict
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   bit         tx_calm;             // sender offers back to back while set
   bit         long_hold_armed;     // asks the receiver for one long hold-off

   // Directed table. Where the answer is obvious it is typed in; an empty
   // string hands the row to the predictor.
   conv_req_type directed_reqs [DIRECTED_ROWS] = '{
      '{64'd0,                  5'd10},
      '{64'd0,                  5'd2},
      '{64'd0,                  5'd16},
      '{64'd1,                  5'd2},
      '{64'hffff_ffff_ffff_ffff, 5'd16},
      '{64'hffff_ffff_ffff_ffff, 5'd10},
      '{64'hffff_ffff_ffff_ffff, 5'd2},
      '{64'hffff_ffff_ffff_ffff, 5'd8},
      '{64'd255,                5'd0},
      '{64'd255,                5'd1},
      '{64'd255,                5'd17},
      '{64'd255,                5'd31},
      '{64'h8000_0000_0000_0000, 5'd2},
      '{64'd15,                 5'd16},
      '{64'd10,                 5'd16},
      '{64'd9,                  5'd10},
      '{64'd16,                 5'd16},
      '{64'hfedc_ba98_7654_3210, 5'd16},
      '{64'h0123_4567_89ab_cdef, 5'd16},
      '{64'haaaa_aaaa_aaaa_aaaa, 5'd16},
      '{64'd12345,              5'd3},
      '{64'h5555_5555_5555_5555, 5'd4},
      '{64'd1000,               5'd7},
      '{64'd99,                 5'd9},
      '{64'hdead_beef_cafe_f00d, 5'd13}
   };

   string directed_text [DIRECTED_ROWS] = '{
      "0",
      "0",
      "0",
      "1",
      "ffffffffffffffff",
      "18446744073709551615",
      "",
      "1777777777777777777777",
      "11111111",                    // radix below two folds to binary
      "11111111",
      "ff",                          // radix above sixteen folds to hex
      "ff",
      "",
      "f",
      "a",
      "9",
      "10",
      "fedcba9876543210",
      "123456789abcdef",
      "aaaaaaaaaaaaaaaa",
      "",
      "",
      "",
      "",
      ""
   };

   unsigned_to_radix_ascii_core #(
      .VALUE_WIDTH (VALUE_W),
      .MAX_DIGITS  (ura_pkg::MAX_DIGITS_DEF)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic logic [ura_pkg::CHAR_W-1:0] char_of_digit(
      input logic [ura_pkg::DIGIT_W-1:0] d);
      int c;
      if (d < 4'd10) begin
         c = int'("0") + int'(d);
      end else begin
         c = int'("a") + int'(d) - 10;
      end
      return c[ura_pkg::CHAR_W-1:0];
   endfunction

   // Repeated division; remainders gathered least significant first, then
   // queued most significant first with the final one flagged.
   task automatic predict_digits(input logic [63:0] value,
                                 input logic [ura_pkg::RADIX_W-1:0] radix);
      logic [63:0]                 quotient;
      logic [63:0]                 base;
      logic [ura_pkg::DIGIT_W-1:0] rem_lsf [64];
      int                          count;
      quotient = value & VALUE_MASK;
      base     = 64'(radix);
      if (radix < ura_pkg::RADIX_MIN) begin
         base = 64'(ura_pkg::RADIX_MIN);
      end else if (radix > ura_pkg::RADIX_MAX) begin
         base = 64'(ura_pkg::RADIX_MAX);
      end
      count = 0;
      do begin
         rem_lsf[count] = ura_pkg::DIGIT_W'(quotient % base);
         quotient       = quotient / base;
         count++;
      end while (quotient != 64'd0 && count < DIGIT_CAP);
      for (int k = count - 1; k >= 0; k--) begin
         expected_digits.push_back(digit_exp_type'{char_of_digit(rem_lsf[k]), k == 0});
      end
   endtask

   task automatic queue_text_digits(input string text);
      byte c;
      for (int i = 0; i < text.len(); i++) begin
         c = text[i];
         expected_digits.push_back(digit_exp_type'{c[ura_pkg::CHAR_W-1:0],
                                                   i == text.len() - 1});
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTS) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int idle_len(input bit calm);
      int pick;
      if (calm) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         return 0;
      end else if (pick < 96) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // Mix of full-width values, shortened ones (keeps the run brisk) and edges.
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          pick;
      v    = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         v = v >> $urandom_range(1, 63);
      end else if (pick == 4) begin
         v = 64'd0;
      end else if (pick == 5) begin
         v = {64{1'b1}};
      end else if (pick == 6) begin
         v = 64'd1 << $urandom_range(0, 63);
      end
      return v;
   endfunction

   function automatic logic [ura_pkg::RADIX_W-1:0] random_radix();
      if ($urandom_range(0, 99) < 85) begin
         return ura_pkg::RADIX_W'($urandom_range(2, 16));
      end
      // whole field, folding cases included
      return ura_pkg::RADIX_W'($urandom_range(0, 31));
   endfunction

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Scoreboard: expectations are queued on the accepting edge of a request,
   // then each digit transfer is checked against the oldest one.
   // ------------------------------------------------------------------

   always @(posedge clock) begin : scoreboard
      digit_exp_type want;
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (pending_text.len() != 0) begin
               queue_text_digits(pending_text);
            end else begin
               predict_digits(req_value, req_radix);
            end
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("digit 0x%0h with nothing outstanding", rsp_digit_char));
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.ch) begin
                  report_mismatch($sformatf("digit_char 0x%0h, wanted 0x%0h",
                                            rsp_digit_char, want.ch));
               end
               if (rsp_last_digit !== want.last) begin
                  report_mismatch($sformatf("last_digit %b, wanted %b",
                                            rsp_last_digit, want.last));
               end
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0)
                || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls at the falling edge, calm spells now and then,
   // and one long hold-off once a digit is waiting so the block backs up.
   // ------------------------------------------------------------------

   initial begin : receiver
      int hold_left;
      int calm_left;
      bit rx_calm;
      bit long_hold_done;
      hold_left      = 0;
      calm_left      = 0;
      rx_calm        = 1'b0;
      long_hold_done = 1'b0;
      rsp_stall      = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_armed && !long_hold_done && rsp_valid === 1'b1) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (calm_left == 0) begin
            calm_left = $urandom_range(50, 300);
            rx_calm   = ($urandom_range(0, 3) == 0);
         end else begin
            calm_left--;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            hold_left = idle_len(rx_calm);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Offer one request from the falling edge after the previous transfer,
   // after an optional gap, and hold it until it is taken.
   task automatic offer(input logic [63:0] value, input logic [ura_pkg::RADIX_W-1:0] radix,
                        input string text);
      int gap;
      gap = idle_len(tx_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pending_text = text;
      req_value   <= value;
      req_radix   <= radix;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   initial begin : stimulus
      req_valid       = 1'b0;
      req_value       = 64'd0;
      req_radix       = '0;
      pending_text    = "";
      tx_calm         = 1'b0;
      long_hold_armed = 1'b0;

      while (reset !== 1'b0) @(negedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer(directed_reqs[i].value, directed_reqs[i].radix, directed_text[i]);
      end

      // random items, sender calm spells re-chosen every dozen
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 12 == 0) begin
            tx_calm = ($urandom_range(0, 2) == 0);
         end
         if (n == 8) begin
            // back-pressure episode: sender offers without pause meanwhile
            tx_calm         = 1'b1;
            long_hold_armed = 1'b1;
         end
         offer(random_value(), random_radix(), "");
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // the watchdog covers a block that never delivers
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
